### rtl/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to Euler XYZ block.
// This file has no dependencies.
package qte_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF  = 16;

    localparam int FRAC_BITS = 30;
    localparam int PW  = 32;  // product, 30 fraction bits
    localparam int MW  = 35;  // matrix term
    localparam int SW  = 32;  // clamped sine
    localparam int NW  = 61;  // radicand
    localparam int RW  = 62;  // root accumulator
    localparam int CW  = MW + 3;  // CORDIC vector
    localparam int AW  = 26;  // angle, deg * 2^16
    localparam int OW  = 16;
    localparam int SQRT_STAGES = 31;

    localparam int LIM_XZ = 23040;
    localparam int LIM_Y  = 11520;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [MW-1:0] t_mat;
    typedef logic signed [SW-1:0] t_sval;
    typedef logic [NW-1:0]        t_rad;
    typedef logic [RW-1:0]        t_root;
    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [AW-1:0] t_ang;
    typedef logic [QAW:0]         t_cnt;

    localparam t_mat  ONE_M  = t_mat'(64'sd1 <<< FRAC_BITS);
    localparam t_mat  NONE_M = -ONE_M;
    localparam t_rad  ONE_SQ = t_rad'(1) << (2 * FRAC_BITS);
    localparam t_ang  DEG90  = t_ang'(90 * 65536);
    localparam t_ang  DEG180 = t_ang'(180 * 65536);

    typedef struct packed {
        t_sval s;
        t_mat  xy;
        t_mat  xx;
        t_mat  zy;
        t_mat  zx;
        logic  lock;
    } t_job;

    function automatic t_ang atan_deg(input int k);
        t_ang v;
        case (k)
            0:  v = t_ang'(2949120);
            1:  v = t_ang'(1740967);
            2:  v = t_ang'(919879);
            3:  v = t_ang'(466945);
            4:  v = t_ang'(234379);
            5:  v = t_ang'(117304);
            6:  v = t_ang'(58666);
            7:  v = t_ang'(29335);
            8:  v = t_ang'(14668);
            9:  v = t_ang'(7334);
            10: v = t_ang'(3667);
            11: v = t_ang'(1833);
            12: v = t_ang'(917);
            13: v = t_ang'(458);
            14: v = t_ang'(229);
            15: v = t_ang'(115);
            16: v = t_ang'(57);
            17: v = t_ang'(29);
            18: v = t_ang'(14);
            19: v = t_ang'(7);
            20: v = t_ang'(4);
            21: v = t_ang'(2);
            22: v = t_ang'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/qte_quat_if.sv
// Input channel: one quaternion item with valid/ready.
// Depends on nothing.
interface qte_quat_if #(parameter int CB = 16);
    logic valid;
    logic ready;
    logic signed [CB-1:0] quat_x;
    logic signed [CB-1:0] quat_y;
    logic signed [CB-1:0] quat_z;
    logic signed [CB-1:0] quat_w;
    modport source(output valid, output quat_x, output quat_y, output quat_z,
                   output quat_w, input ready);
    modport sink(input valid, input quat_x, input quat_y, input quat_z,
                 input quat_w, output ready);
endinterface

### rtl/qte_euler_if.sv
// Output channel: one Euler angle item with valid/ready.
// Depends on nothing.
interface qte_euler_if;
    logic valid;
    logic ready;
    logic signed [15:0] angle_x;
    logic signed [14:0] angle_y;
    logic signed [15:0] angle_z;
    modport source(output valid, output angle_x, output angle_y, output angle_z,
                   input ready);
    modport sink(input valid, input angle_x, input angle_y, input angle_z,
                 output ready);
endinterface

### rtl/qte_front.sv
// Front: accepts quaternions, forms products and matrix terms, picks atan2 arguments.
// Depends on qte_pkg and qte_quat_if.
module qte_front #(
    parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qte_quat_if.sink          i_quat,
    input  qte_pkg::t_cnt     i_qcnt,
    output logic              o_push,
    output qte_pkg::t_job     o_job
);
    localparam int CB  = COMPONENT_BITS;
    localparam int SH  = 2 * (CB - 1) - qte_pkg::FRAC_BITS;
    localparam int SHR = (SH > 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;

    function automatic qte_pkg::t_prod mulq(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
        logic signed [2*CB-1:0] p;
        p = a * b;
        return qte_pkg::t_prod'(p >>> SHR) <<< SHL;
    endfunction

    function automatic qte_pkg::t_mat dsum(input qte_pkg::t_prod a, input qte_pkg::t_prod b);
        return (qte_pkg::t_mat'(a) + qte_pkg::t_mat'(b)) <<< 1;
    endfunction

    function automatic qte_pkg::t_mat ddif(input qte_pkg::t_prod a, input qte_pkg::t_prod b);
        return (qte_pkg::t_mat'(a) - qte_pkg::t_mat'(b)) <<< 1;
    endfunction

    logic r_v1, r_v2;
    qte_pkg::t_prod r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz, r_pwx, r_pwy, r_pwz;
    qte_pkg::t_job  r_job, n_job;
    qte_pkg::t_mat  m11, m12, m22, m32, m13, m23, m33;
    logic           accept;

    assign i_quat.ready = (qte_pkg::t_cnt'(r_v1) + qte_pkg::t_cnt'(r_v2) + i_qcnt)
                          < qte_pkg::t_cnt'(qte_pkg::QDEPTH);
    assign accept = i_quat.valid && i_quat.ready;

    always_comb begin
        m11 = qte_pkg::ONE_M - dsum(r_pyy, r_pzz);
        m12 = ddif(r_pxy, r_pwz);
        m22 = qte_pkg::ONE_M - dsum(r_pxx, r_pzz);
        m32 = dsum(r_pyz, r_pwx);
        m13 = dsum(r_pxz, r_pwy);
        m23 = ddif(r_pyz, r_pwx);
        m33 = qte_pkg::ONE_M - dsum(r_pxx, r_pyy);
        n_job.lock = (m13 >= qte_pkg::ONE_M) || (m13 <= qte_pkg::NONE_M);
        if (m13 > qte_pkg::ONE_M) begin
            n_job.s = qte_pkg::t_sval'(qte_pkg::ONE_M);
        end else if (m13 < qte_pkg::NONE_M) begin
            n_job.s = qte_pkg::t_sval'(qte_pkg::NONE_M);
        end else begin
            n_job.s = qte_pkg::t_sval'(m13);
        end
        if (n_job.lock) begin
            n_job.xy = m32;
            n_job.xx = m22;
        end else begin
            n_job.xy = -m23;
            n_job.xx = m33;
        end
        n_job.zy = -m12;
        n_job.zx = m11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
        if (accept) begin
            r_pxx <= mulq(i_quat.quat_x, i_quat.quat_x);
            r_pyy <= mulq(i_quat.quat_y, i_quat.quat_y);
            r_pzz <= mulq(i_quat.quat_z, i_quat.quat_z);
            r_pxy <= mulq(i_quat.quat_x, i_quat.quat_y);
            r_pxz <= mulq(i_quat.quat_x, i_quat.quat_z);
            r_pyz <= mulq(i_quat.quat_y, i_quat.quat_z);
            r_pwx <= mulq(i_quat.quat_w, i_quat.quat_x);
            r_pwy <= mulq(i_quat.quat_w, i_quat.quat_y);
            r_pwz <= mulq(i_quat.quat_w, i_quat.quat_z);
        end
        if (r_v1) begin
            r_job <= n_job;
        end
    end

    assign o_push = r_v2;
    assign o_job  = r_job;
endmodule

### rtl/qte_queue.sv
// Short job queue between front and back.
// Depends on qte_pkg.
module qte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qte_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output qte_pkg::t_cnt o_cnt,
    output qte_pkg::t_job o_job
);
    qte_pkg::t_job            r_mem [qte_pkg::QDEPTH];
    logic [qte_pkg::QAW-1:0]  r_wr, r_rd;
    qte_pkg::t_cnt            r_cnt;
    logic                     pop;

    assign o_empty = (r_cnt == '0);
    assign pop     = i_pop && !o_empty;
    assign o_cnt   = r_cnt;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + qte_pkg::t_cnt'(i_push) - qte_pkg::t_cnt'(pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

### rtl/qte_isqrt.sv
// Pipelined bit-pair integer square root, one result bit per stage.
// Depends on qte_pkg.
module qte_isqrt (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_rad i_n,
    output qte_pkg::t_root o_root
);
    localparam int S = qte_pkg::SQRT_STAGES;

    qte_pkg::t_rad  r_n [S];
    qte_pkg::t_root r_r [S];

    for (genvar j = 0; j < S; j++) begin : g_stage
        localparam qte_pkg::t_root BIT = qte_pkg::t_root'(1) << (2 * (S - 1 - j));
        qte_pkg::t_root n_in, r_in, t;
        if (j == 0) begin : g_first
            assign n_in = qte_pkg::t_root'(i_n);
            assign r_in = '0;
        end else begin : g_next
            assign n_in = qte_pkg::t_root'(r_n[j-1]);
            assign r_in = r_r[j-1];
        end
        assign t = r_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_in >= t) begin
                    r_n[j] <= qte_pkg::t_rad'(n_in - t);
                    r_r[j] <= (r_in >> 1) + BIT;
                end else begin
                    r_n[j] <= qte_pkg::t_rad'(n_in);
                    r_r[j] <= r_in >> 1;
                end
            end
        end
    end

    assign o_root = r_r[S-1];
endmodule

### rtl/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 in degrees, rounded to 1/128 degree and clamped.
// Depends on qte_pkg.
module qte_cordic #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int LIM           = qte_pkg::LIM_XZ
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  qte_pkg::t_mat              i_y,
    input  qte_pkg::t_mat              i_x,
    output logic signed [qte_pkg::OW-1:0] o_ang
);
    localparam int N = CORDIC_STAGES;
    localparam qte_pkg::t_ang LIMA = qte_pkg::t_ang'(LIM);

    qte_pkg::t_cw  r_x [N+1];
    qte_pkg::t_cw  r_y [N+1];
    qte_pkg::t_ang r_a [N+1];
    logic          r_h [N+1];
    logic signed [qte_pkg::OW-1:0] r_o;

    qte_pkg::t_cw  px, py;
    qte_pkg::t_ang pa, rnd;
    logic          ph;

    always_comb begin
        px = qte_pkg::t_cw'(i_x);
        py = qte_pkg::t_cw'(i_y);
        pa = '0;
        ph = 1'b0;
        if (i_y == '0) begin
            ph = 1'b1;
            pa = (i_x < 0) ? qte_pkg::DEG180 : '0;
        end else if (i_x == '0) begin
            ph = 1'b1;
            pa = (i_y > 0) ? qte_pkg::DEG90 : -qte_pkg::DEG90;
        end else if (i_x < 0) begin
            pa = (i_y > 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
            px = -px;
            py = -py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= px;
            r_y[0] <= py;
            r_a[0] <= pa;
            r_h[0] <= ph;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam int K = i % 32;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h[i+1] <= r_h[i];
                if (r_h[i]) begin
                    r_x[i+1] <= r_x[i];
                    r_y[i+1] <= r_y[i];
                    r_a[i+1] <= r_a[i];
                end else if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> K);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> K);
                    r_a[i+1] <= r_a[i] + qte_pkg::atan_deg(K);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> K);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> K);
                    r_a[i+1] <= r_a[i] - qte_pkg::atan_deg(K);
                end
            end
        end
    end

    assign rnd = (r_a[N] + qte_pkg::t_ang'(256)) >>> 9;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (rnd > LIMA) begin
                r_o <= qte_pkg::OW'(LIMA);
            end else if (rnd < -LIMA) begin
                r_o <= qte_pkg::OW'(-LIMA);
            end else begin
                r_o <= qte_pkg::OW'(rnd);
            end
        end
    end

    assign o_ang = r_o;
endmodule

### rtl/qte_back.sv
// Back: square root for the cosine, three CORDIC pipes, output register.
// Depends on qte_pkg, qte_isqrt, qte_cordic and qte_euler_if.
module qte_back #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  qte_pkg::t_job i_job,
    output logic          o_pop,
    qte_euler_if.source   o_euler
);
    localparam int S = qte_pkg::SQRT_STAGES;
    localparam int L = S + CORDIC_STAGES + 3;

    logic           en;
    logic [L-1:0]   r_vld, r_lck;
    qte_pkg::t_job  r_j [S+1];
    qte_pkg::t_rad  r_n0;
    qte_pkg::t_root root;
    logic signed [2*qte_pkg::SW-1:0] ss;
    logic signed [qte_pkg::OW-1:0] ax, ay, az;
    logic           r_out_valid;
    logic signed [15:0] r_ax, r_az;
    logic signed [14:0] r_ay;

    assign en    = !r_out_valid || o_euler.ready;
    assign o_pop = en && !i_empty;
    assign ss    = i_job.s * i_job.s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[L-2:0], o_pop};
            r_out_valid <= r_vld[L-1];
        end
        if (en) begin
            r_lck <= {r_lck[L-2:0], i_job.lock};
            r_j[0] <= i_job;
            r_n0 <= qte_pkg::ONE_SQ - qte_pkg::t_rad'(ss);
            for (int t = 1; t <= S; t++) begin
                r_j[t] <= r_j[t-1];
            end
            r_ax <= ax;
            r_ay <= ay[14:0];
            r_az <= r_lck[L-1] ? '0 : az;
        end
    end

    qte_isqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_n0),
        .o_root(root)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIM(qte_pkg::LIM_Y)) u_cy (
        .i_clk(i_clk),
        .i_en (en),
        .i_y  (qte_pkg::t_mat'(r_j[S].s)),
        .i_x  (qte_pkg::t_mat'(root)),
        .o_ang(ay)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIM(qte_pkg::LIM_XZ)) u_cx (
        .i_clk(i_clk),
        .i_en (en),
        .i_y  (r_j[S].xy),
        .i_x  (r_j[S].xx),
        .o_ang(ax)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .LIM(qte_pkg::LIM_XZ)) u_cz (
        .i_clk(i_clk),
        .i_en (en),
        .i_y  (r_j[S].zy),
        .i_x  (r_j[S].zx),
        .o_ang(az)
    );

    assign o_euler.valid   = r_out_valid;
    assign o_euler.angle_x = r_ax;
    assign o_euler.angle_y = r_ay;
    assign o_euler.angle_z = r_az;
endmodule

### rtl/quaternion_to_euler_xyz.sv
// Quaternion to Euler XYZ converter, top level.
// From input to output item the path runs through two front stages, the queue,
// a radicand stage, 31 square-root stages, CORDIC_STAGES + 2 CORDIC stages and the
// output register.
// Throughput one item per cycle; the back pipeline holds as a whole while the output stalls.
// Synchronous active-low reset clears the valid chains, the queue pointers and the queue count only.
module quaternion_to_euler_xyz #(
    parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    logic          push, pop, empty;
    qte_pkg::t_job fjob, qjob;
    qte_pkg::t_cnt qcnt;

    qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quat (i_quat),
        .i_qcnt (qcnt),
        .o_push (push),
        .o_job  (fjob)
    );

    qte_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (fjob),
        .i_pop  (pop),
        .o_empty(empty),
        .o_cnt  (qcnt),
        .o_job  (qjob)
    );

    qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_job  (qjob),
        .o_pop  (pop),
        .o_euler(o_euler)
    );
endmodule

### sim/qte_euler_checker.sv
// Checker for quaternion_to_euler_xyz: watches both channels, predicts Euler angles
// for each accepted quaternion item and compares them with the output items.
// Depends on qte_pkg, qte_quat_if and qte_euler_if.
`timescale 1ns / 1ps
module qte_euler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if         quat,
    qte_euler_if        euler,
    output int          o_errors,
    output int          o_outstanding,
    output int          o_lock_seen
);
    typedef struct {
        logic signed [15:0] ax;
        logic signed [14:0] ay;
        logic signed [15:0] az;
    } t_angles;

    t_angles angle_q[$];

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        return a * b;  // 16-bit components: 2*15 fraction bits = 30 exactly
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint cordic_atan2(longint y, longint x);
        longint base, acc, xn, yn;
        base = 0;
        acc = 0;
        if (y == 0) return (x < 0) ? 180 * 65536 : 0;
        if (x == 0) return (y > 0) ? 90 * 65536 : -90 * 65536;
        if (x < 0) begin
            base = (y > 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STAGES_DEF; i++) begin
            if (y >= 0) begin
                xn = x + fdiv(y, i);
                yn = y - fdiv(x, i);
                acc += longint'(qte_pkg::atan_deg(i));
            end else begin
                xn = x - fdiv(y, i);
                yn = y + fdiv(x, i);
                acc -= longint'(qte_pkg::atan_deg(i));
            end
            x = xn;
            y = yn;
        end
        return base + acc;
    endfunction

    function automatic longint round_clamp(longint a, longint lim);
        longint r;
        r = fdiv(a + 256, 9);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(longint x, longint y, longint z, longint w,
                                         output bit lock);
        longint one, m11, m12, m22, m32, m13, m23, m33, s, c, ax, ay, az;
        t_angles r;
        one = 64'sd1 <<< qte_pkg::FRAC_BITS;
        m11 = one - 2 * (prod_q30(y, y) + prod_q30(z, z));
        m12 = 2 * (prod_q30(x, y) - prod_q30(w, z));
        m22 = one - 2 * (prod_q30(x, x) + prod_q30(z, z));
        m32 = 2 * (prod_q30(y, z) + prod_q30(w, x));
        m13 = 2 * (prod_q30(x, z) + prod_q30(w, y));
        m23 = 2 * (prod_q30(y, z) - prod_q30(w, x));
        m33 = one - 2 * (prod_q30(x, x) + prod_q30(y, y));
        s = m13;
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = root_floor((64'd1 << (2 * qte_pkg::FRAC_BITS)) - longint'(s * s));
        ay = cordic_atan2(s, c);
        lock = (m13 >= one) || (m13 <= -one);
        az = 0;
        if (!lock) begin
            ax = cordic_atan2(-m23, m33);
            az = round_clamp(cordic_atan2(-m12, m11), qte_pkg::LIM_XZ);
        end else begin
            ax = cordic_atan2(m32, m22);
        end
        r.ax = 16'(round_clamp(ax, qte_pkg::LIM_XZ));
        r.ay = 15'(round_clamp(ay, qte_pkg::LIM_Y));
        r.az = 16'(az);
        return r;
    endfunction

    assign o_outstanding = angle_q.size();

    always @(posedge i_clk) begin
        t_angles e;
        bit lk;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_lock_seen <= 0;
        end else begin
            if (quat.valid && quat.ready) begin
                e = euler_of(quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w, lk);
                angle_q.push_back(e);
                if (lk) o_lock_seen <= o_lock_seen + 1;
            end
            if (euler.valid && euler.ready) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time,
                             euler.angle_x, euler.angle_y, euler.angle_z);
                    o_errors <= o_errors + 1;
                end else begin
                    e = angle_q.pop_front();
                    if (e.ax !== euler.angle_x || e.ay !== euler.angle_y
                        || e.az !== euler.angle_z) begin
                        $display("%0t: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $time, e.ax, e.ay, e.az,
                                 euler.angle_x, euler.angle_y, euler.angle_z);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/tb_quaternion_to_euler_xyz.sv
// Testbench top for quaternion_to_euler_xyz: drives directed and random quaternions
// with random idling on both channels, and reports the checker's verdict.
// Depends on qte_pkg, the interfaces, the block and qte_euler_checker.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_xyz;
    logic i_clk = 0;
    logic i_rst_n = 0;
    int errors, outstanding, lock_seen;
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;
    int idle_cycles = 0;
    int sent = 0;

    qte_quat_if #(.CB(16)) quat ();
    qte_euler_if euler ();

    quaternion_to_euler_xyz dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_quat(quat.sink), .o_euler(euler.source)
    );

    qte_euler_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .quat(quat), .euler(euler),
        .o_errors(errors), .o_outstanding(outstanding), .o_lock_seen(lock_seen)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        quat.valid = 0;
        quat.quat_x = 0;
        quat.quat_y = 0;
        quat.quat_z = 0;
        quat.quat_w = 0;
        euler.ready = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv) euler.ready <= 0;
        else euler.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((quat.valid && quat.ready) || (euler.valid && euler.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_quat(input logic [15:0] x, y, z, w);
        quat.valid <= 1;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        quat.quat_w <= w;
        @(posedge i_clk);
        while (!quat.ready) @(posedge i_clk);
        sent++;
        if ($urandom_range(99) < send_idle) begin
            quat.valid <= 0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [15:0] a, b, c, d;
        int k;
        k = $urandom_range(9);
        a = $urandom; b = $urandom; c = $urandom; d = $urandom;
        if (k < 4) begin
            // roughly unit quaternion: small components around a dominant one
            a = 16'($signed(a) >>> $urandom_range(8, 1));
            b = 16'($signed(b) >>> $urandom_range(8, 1));
            c = 16'($signed(c) >>> $urandom_range(8, 1));
        end else if (k < 6) begin
            // near gimbal lock: w == +-y or w == -+y magnitude ~ 0.7071
            d = ($urandom_range(1)) ? 16'sd23170 : -16'sd23170;
            b = ($urandom_range(1)) ? d : -d;
            a = 16'($signed(a) >>> 10);
            c = 16'($signed(c) >>> 10);
            if ($urandom_range(1)) begin a = 0; c = 0; end
        end
        send_quat(a, b, c, d);
    endtask

    task automatic drain();
        quat.valid <= 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] v[6];
        v = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h5a82};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_idle = 6;
        recv_idle = 53;
        send_quat(0, 0, 0, 16'h7fff);
        send_quat(0, 0, 0, 0);
        send_quat(16'h7fff, 0, 0, 0);
        send_quat(0, 16'h7fff, 0, 0);
        send_quat(0, 0, 16'h7fff, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(0, 16'h5a82, 0, 16'h5a82);
        send_quat(0, 16'ha57e, 0, 16'h5a82);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_quat(0, 16'h8000, 0, 16'h8000);
        send_quat(16'h8000, 0, 0, 16'h7fff);
        for (int i = 0; i < 12; i++)
            send_quat(v[$urandom_range(5)], v[$urandom_range(5)],
                      v[$urandom_range(5)], v[$urandom_range(5)]);
        for (int i = 0; i < 150; i++) send_random();
        drain();
        hold_recv = 1;
        fork
            repeat (200) @(posedge i_clk);
            for (int i = 0; i < 80; i++) send_random();
        join_any
        hold_recv = 0;
        wait fork;
        send_idle = 53;
        recv_idle = 6;
        for (int i = 0; i < 150; i++) send_random();
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < 120; i++) send_random();
        drain();
        repeat (100) @(posedge i_clk);
        $display("Ran %0d quaternion items, %0d in gimbal lock, under varied idling.",
                 sent, lock_seen);
        if (errors == 0 && outstanding == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

### filelist.f
rtl/qte_pkg.sv
rtl/qte_quat_if.sv
rtl/qte_euler_if.sv
rtl/qte_front.sv
rtl/qte_queue.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/qte_back.sv
rtl/quaternion_to_euler_xyz.sv
sim/qte_euler_checker.sv
sim/tb_quaternion_to_euler_xyz.sv
